// ===== rtl/cgrm_pkg.sv =====
// ----------------------------------------------------------------------------
// cgrm_pkg: shared types and constants for the conic gradient run merger
// Widths, register codes, the queue item and the front/back FSM states.
// ----------------------------------------------------------------------------
package cgrm_pkg;

    // Field widths
    localparam int ANGLE_BITS = 16;
    localparam int COORD_BITS = 12;
    localparam int CIDX_BITS  = 10;
    localparam int RANGE_BITS = 17;
    localparam int PROD_BITS  = ANGLE_BITS + CIDX_BITS;
    localparam int CNT_BITS   = $clog2(CIDX_BITS);

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELD_BITS  = 2 * COORD_BITS + ANGLE_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 3 * COORD_BITS + CIDX_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = RANGE_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ARC_BASE   = 2'd0,
        CFG_ARC_WIDTH  = 2'd1,
        CFG_RAMP_RANGE = 2'd2,
        CFG_CIDX_MAX   = 2'd3
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic [ANGLE_BITS-1:0] ARC_BASE_RST   = '0;
    localparam logic [RANGE_BITS-1:0] ARC_WIDTH_RST  = 17'd65536;
    localparam logic [RANGE_BITS-1:0] RAMP_RANGE_RST = 17'd65536;
    localparam logic [CIDX_BITS-1:0]  CIDX_MAX_RST   = 10'd359;

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int FCNT_BITS  = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [ANGLE_BITS-1:0] arc_base;
        logic [RANGE_BITS-1:0] arc_width;
        logic [RANGE_BITS-1:0] ramp_range;
        logic [CIDX_BITS-1:0]  cidx_max;
    } cfg_t;

    // One classified pixel
    typedef struct packed {
        logic signed [COORD_BITS-1:0] row;
        logic signed [COORD_BITS-1:0] x;
        logic                         span_end;
        logic                         in_arc;
        logic [CIDX_BITS-1:0]         idx;
    } qitem_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_FIRST,
        B_SECOND
    } back_state_t;

endpackage

// ===== rtl/cgrm_front.sv =====
// ----------------------------------------------------------------------------
// cgrm_front: pixel classifier and color index divider
// Takes one pixel, finds its arc offset, then forms d*max/range with one
// multiply and a restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cgrm_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cgrm_pkg::cfg_t                       cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [cgrm_pkg::COORD_BITS-1:0] in_row,
    input  logic signed [cgrm_pkg::COORD_BITS-1:0] in_x,
    input  logic [cgrm_pkg::ANGLE_BITS-1:0]      in_angle,
    input  logic                                 in_span_end,
    output logic                                 push,
    output cgrm_pkg::qitem_t                     push_item,
    input  logic                                 q_full
);

    cgrm_pkg::front_state_t state_reg, state_next;

    logic signed [cgrm_pkg::COORD_BITS-1:0] row_reg, x_reg;
    logic                                   span_end_reg;
    logic                                   in_arc_reg;
    logic [cgrm_pkg::ANGLE_BITS-1:0]        d_reg;
    logic [cgrm_pkg::PROD_BITS-1:0]         prod_reg;
    logic [cgrm_pkg::RANGE_BITS-1:0]        rem_reg, rem_next;
    logic [cgrm_pkg::CIDX_BITS-1:0]         quot_reg;
    logic [cgrm_pkg::CNT_BITS-1:0]          cnt_reg;

    logic                                   accept;
    logic                                   last_step;
    logic [cgrm_pkg::RANGE_BITS-1:0]        range_eff;
    logic [cgrm_pkg::ANGLE_BITS-1:0]        d_raw;
    logic [cgrm_pkg::RANGE_BITS-1:0]        d_ext;
    logic [cgrm_pkg::ANGLE_BITS-1:0]        d_clamp;
    logic                                   in_arc_now;
    logic [cgrm_pkg::RANGE_BITS-1:0]        rem_src;
    logic [cgrm_pkg::CIDX_BITS-1:0]         prod_lo;
    logic [cgrm_pkg::CNT_BITS-1:0]          bit_idx;
    logic [cgrm_pkg::RANGE_BITS:0]          trial;
    logic                                   qbit;

    // Offset from arc start, arc test and clamp to the ramp
    always_comb
    begin
        range_eff  = (cfg.ramp_range == '0) ? cgrm_pkg::RANGE_BITS'(1) : cfg.ramp_range;
        d_raw      = in_angle - cfg.arc_base;
        d_ext      = cgrm_pkg::RANGE_BITS'(d_raw);
        in_arc_now = (d_ext <= cfg.arc_width);
        d_clamp    = (d_ext > range_eff) ? range_eff[cgrm_pkg::ANGLE_BITS-1:0] : d_raw;
    end

    // One restoring division step
    always_comb
    begin
        rem_src = (cnt_reg == '0)
                ? cgrm_pkg::RANGE_BITS'(prod_reg[cgrm_pkg::PROD_BITS-1:cgrm_pkg::CIDX_BITS])
                : rem_reg;
        prod_lo = prod_reg[cgrm_pkg::CIDX_BITS-1:0];
        bit_idx = cgrm_pkg::CNT_BITS'(cgrm_pkg::CIDX_BITS - 1) - cnt_reg;
        trial   = {rem_src, prod_lo[bit_idx]};
        qbit    = (trial >= {1'b0, range_eff});
        rem_next = qbit ? cgrm_pkg::RANGE_BITS'(trial - {1'b0, range_eff})
                        : trial[cgrm_pkg::RANGE_BITS-1:0];
        last_step = (cnt_reg == cgrm_pkg::CNT_BITS'(cgrm_pkg::CIDX_BITS - 1));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cgrm_pkg::F_IDLE:
            begin
                if (in_valid)
                    state_next = in_arc_now ? cgrm_pkg::F_MUL : cgrm_pkg::F_PUSH;
            end
            cgrm_pkg::F_MUL:
                state_next = cgrm_pkg::F_DIV;
            cgrm_pkg::F_DIV:
            begin
                if (last_step)
                    state_next = cgrm_pkg::F_PUSH;
            end
            cgrm_pkg::F_PUSH:
            begin
                if (!q_full)
                    state_next = cgrm_pkg::F_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        unique case (state_reg)
            cgrm_pkg::F_IDLE: in_ready = 1'b1;
            cgrm_pkg::F_MUL:  ;
            cgrm_pkg::F_DIV:  ;
            cgrm_pkg::F_PUSH: push = !q_full;
        endcase
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cgrm_pkg::F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == cgrm_pkg::F_DIV)
                cnt_reg <= last_step ? '0 : cnt_reg + cgrm_pkg::CNT_BITS'(1);
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg      <= in_row;
            x_reg        <= in_x;
            span_end_reg <= in_span_end;
            in_arc_reg   <= in_arc_now;
            d_reg        <= d_clamp;
            quot_reg     <= '0;
        end
        if (state_reg == cgrm_pkg::F_MUL)
            prod_reg <= cgrm_pkg::PROD_BITS'(d_reg) * cgrm_pkg::PROD_BITS'(cfg.cidx_max);
        if (state_reg == cgrm_pkg::F_DIV)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[cgrm_pkg::CIDX_BITS-2:0], qbit};
        end
    end

    always_comb
    begin
        push_item.row      = row_reg;
        push_item.x        = x_reg;
        push_item.span_end = span_end_reg;
        push_item.in_arc   = in_arc_reg;
        push_item.idx      = quot_reg;
    end

endmodule

// ===== rtl/cgrm_fifo.sv =====
// ----------------------------------------------------------------------------
// cgrm_fifo: short queue of classified pixels
// Decouples the divider front from the run merging back.
// ----------------------------------------------------------------------------
module cgrm_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cgrm_pkg::qitem_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output cgrm_pkg::qitem_t head_item
);

    cgrm_pkg::qitem_t mem_reg [cgrm_pkg::FIFO_DEPTH];

    logic [cgrm_pkg::PTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [cgrm_pkg::FCNT_BITS-1:0] count_reg;

    assign full       = (count_reg == cgrm_pkg::FCNT_BITS'(cgrm_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + cgrm_pkg::PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + cgrm_pkg::PTR_BITS'(1);
            if (push && !pop)
                count_reg <= count_reg + cgrm_pkg::FCNT_BITS'(1);
            else if (pop && !push)
                count_reg <= count_reg - cgrm_pkg::FCNT_BITS'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/cgrm_back.sv =====
// ----------------------------------------------------------------------------
// cgrm_back: run merger
// Merges equal neighbouring indices into runs and emits each closed run
// through an output register; one pixel may close up to two runs.
// ----------------------------------------------------------------------------
module cgrm_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   head_valid,
    input  cgrm_pkg::qitem_t                       head_item,
    output logic                                   pop,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // run_row, run_start_x, run_end_x, color_index (lowest bit up)
    output logic [cgrm_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
    output logic                                   m_axis_tlast
);

    cgrm_pkg::back_state_t state_reg, state_next;

    logic                            run_open_reg, run_open_next;
    logic [cgrm_pkg::CIDX_BITS-1:0]  run_color_reg, run_color_next;
    logic [cgrm_pkg::COORD_BITS-1:0] run_first_reg, run_first_next;

    logic                            out_valid_reg;
    logic [cgrm_pkg::COORD_BITS-1:0] out_row_reg, out_x0_reg, out_x1_reg;
    logic [cgrm_pkg::CIDX_BITS-1:0]  out_color_reg;
    logic                            out_last_reg;

    logic                            go;
    logic                            close1, open_kept, open1, close2;
    logic [cgrm_pkg::CIDX_BITS-1:0]  color1;
    logic [cgrm_pkg::COORD_BITS-1:0] first1;
    logic                            emit;
    logic [cgrm_pkg::COORD_BITS-1:0] emit_x0, emit_x1;
    logic [cgrm_pkg::CIDX_BITS-1:0]  emit_color;
    logic                            emit_last;

    // Run bookkeeping for the head pixel
    always_comb
    begin
        go        = head_valid && (!out_valid_reg || m_axis_tready);
        close1    = run_open_reg
                  && (!head_item.in_arc || (head_item.idx != run_color_reg));
        open_kept = run_open_reg && !close1;
        open1     = open_kept || head_item.in_arc;
        color1    = open_kept ? run_color_reg : head_item.idx;
        first1    = open_kept ? run_first_reg : head_item.x;
        close2    = head_item.span_end && open1;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cgrm_pkg::B_FIRST:
            begin
                if (go && close1 && close2)
                    state_next = cgrm_pkg::B_SECOND;
            end
            cgrm_pkg::B_SECOND:
            begin
                if (go)
                    state_next = cgrm_pkg::B_FIRST;
            end
        endcase
    end

    // State outputs: result selection and run state update
    always_comb
    begin
        pop            = 1'b0;
        emit           = 1'b0;
        emit_x0        = run_first_reg;
        emit_x1        = head_item.x;
        emit_color     = run_color_reg;
        emit_last      = 1'b1;
        run_open_next  = run_open_reg;
        run_color_next = run_color_reg;
        run_first_next = run_first_reg;
        unique case (state_reg)
            cgrm_pkg::B_FIRST:
            begin
                if (go)
                begin
                    run_color_next = color1;
                    run_first_next = first1;
                    if (close1)
                    begin
                        // index change or arc left: run ends one pixel back
                        emit          = 1'b1;
                        emit_x1       = head_item.x - cgrm_pkg::COORD_BITS'(1);
                        emit_last     = !close2;
                        run_open_next = open1;
                        pop           = !close2;
                    end
                    else
                    begin
                        emit          = close2;
                        emit_x0       = first1;
                        emit_color    = color1;
                        run_open_next = open1 && !close2;
                        pop           = 1'b1;
                    end
                end
            end
            cgrm_pkg::B_SECOND:
            begin
                if (go)
                begin
                    emit          = 1'b1;
                    run_open_next = 1'b0;
                    pop           = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cgrm_pkg::B_FIRST;
            run_open_reg  <= 1'b0;
            run_color_reg <= '0;
            run_first_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_open_reg  <= run_open_next;
            run_color_reg <= run_color_next;
            run_first_reg <= run_first_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg   <= head_item.row;
            out_x0_reg    <= emit_x0;
            out_x1_reg    <= emit_x1;
            out_color_reg <= emit_color;
            out_last_reg  <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = cgrm_pkg::OUT_TDATA_BITS'({out_color_reg, out_x1_reg,
                                                      out_x0_reg, out_row_reg});

endmodule

// ===== rtl/conic_gradient_run_merger.sv =====
// ----------------------------------------------------------------------------
// conic_gradient_run_merger: conic gradient color index with run merging
// Classifies scanline pixels against a configurable arc, computes the ramp
// color index and merges equal neighbours into runs.
// ----------------------------------------------------------------------------
// Flow: an in-arc pixel passes the front as accept, multiply, 10 divider steps
//   of one quotient bit each and queue push; others go straight to the push.
//   No new pixel is taken before the last is pushed; the divider sets the rate.
//   A run passes the queue, the back and its output register; a second run of
//   one pixel waits for that register to free. A full queue holds the front.
// Reset: async active low; clears control state, empties the queue, closes any
//   open run and loads the configuration registers with their defaults.
module conic_gradient_run_merger (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cgrm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [cgrm_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // row, pixel_x, angle (lowest bit up)
    input  logic [cgrm_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // run_row, run_start_x, run_end_x, color_index (lowest bit up)
    output logic [cgrm_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
    output logic                                  m_axis_tlast
);

    localparam int RowLo   = 0;
    localparam int XLo     = cgrm_pkg::COORD_BITS;
    localparam int AngleLo = 2 * cgrm_pkg::COORD_BITS;

    cgrm_pkg::cfg_t   cfg_reg;
    cgrm_pkg::qitem_t push_item, head_item;
    logic             push, q_full, pop, head_valid;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arc_base   <= cgrm_pkg::ARC_BASE_RST;
            cfg_reg.arc_width  <= cgrm_pkg::ARC_WIDTH_RST;
            cfg_reg.ramp_range <= cgrm_pkg::RAMP_RANGE_RST;
            cfg_reg.cidx_max   <= cgrm_pkg::CIDX_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cgrm_pkg::CFG_ARC_BASE:
                    cfg_reg.arc_base   <= cfg_wdata[cgrm_pkg::ANGLE_BITS-1:0];
                cgrm_pkg::CFG_ARC_WIDTH:
                    cfg_reg.arc_width  <= cfg_wdata[cgrm_pkg::RANGE_BITS-1:0];
                cgrm_pkg::CFG_RAMP_RANGE:
                    cfg_reg.ramp_range <= cfg_wdata[cgrm_pkg::RANGE_BITS-1:0];
                cgrm_pkg::CFG_CIDX_MAX:
                    cfg_reg.cidx_max   <= cfg_wdata[cgrm_pkg::CIDX_BITS-1:0];
            endcase
        end
    end

    cgrm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_row      (s_axis_tdata[RowLo +: cgrm_pkg::COORD_BITS]),
        .in_x        (s_axis_tdata[XLo +: cgrm_pkg::COORD_BITS]),
        .in_angle    (s_axis_tdata[AngleLo +: cgrm_pkg::ANGLE_BITS]),
        .in_span_end (s_axis_tlast),
        .push        (push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    cgrm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    cgrm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== tb/conic_gradient_run_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conic_gradient_run_checker: scoreboard for the conic gradient run merger
// Watches the register port and both stream channels. It predicts the runs
// that each accepted pixel request closes and compares every returned run,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module conic_gradient_run_checker
    import cgrm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    // row, pixel_x, angle (lowest bit up)
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    input  logic                      s_axis_tlast,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // run_row, run_start_x, run_end_x, color_index (lowest bit up)
    input  logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    input  logic                      m_axis_tlast,
    output int                        fail_count,
    output int                        runs_pending,
    output int                        runs_checked
);

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] end_x;
        logic [CIDX_BITS-1:0]  color;
        logic                  last;
    } run_t;

    // shadow copy of the register file
    logic [ANGLE_BITS-1:0] arc_origin;
    logic [RANGE_BITS-1:0] arc_width;
    logic [RANGE_BITS-1:0] ramp_den;
    logic [CIDX_BITS-1:0]  top_index;

    // run being merged
    bit                    open_run;
    logic [CIDX_BITS-1:0]  open_color;
    logic [COORD_BITS-1:0] open_x;

    run_t runs_due[$];
    int   errors;
    int   checked;

    function automatic void note(input string msg);
        errors++;
        $display("%0t: %s", $time, msg);
    endfunction

    // in-arc test and ramp index of one angle
    function automatic bit ramp_index(input logic [ANGLE_BITS-1:0] ang,
                                      output logic [CIDX_BITS-1:0] idx);
        logic [ANGLE_BITS-1:0] offset;
        logic [RANGE_BITS-1:0] arc_pos;
        logic [RANGE_BITS-1:0] den;
        logic [63:0]           quot;
        offset  = ang - arc_origin;
        arc_pos = RANGE_BITS'(offset);
        den     = (ramp_den == '0) ? RANGE_BITS'(1) : ramp_den;
        idx     = '0;
        if (arc_pos > arc_width)
            return 1'b0;
        if (arc_pos > den)
            arc_pos = den;
        quot = (64'(arc_pos) * 64'(top_index)) / 64'(den);
        if (quot > 64'(top_index))
            quot = 64'(top_index);
        idx = quot[CIDX_BITS-1:0];
        return 1'b1;
    endfunction

    // merge one pixel and queue the runs it closes
    function automatic void merge_pixel(input logic [COORD_BITS-1:0] row,
                                        input logic [COORD_BITS-1:0] x,
                                        input logic [ANGLE_BITS-1:0] ang,
                                        input logic                  span_end);
        logic [CIDX_BITS-1:0] idx;
        bit                   in_arc;
        run_t                 closed [2];
        int                   n;
        n      = 0;
        in_arc = ramp_index(ang, idx);
        // index change or arc exit closes the run one pixel back
        if (open_run && (!in_arc || idx != open_color))
        begin
            closed[n].row     = row;
            closed[n].first_x = open_x;
            closed[n].end_x   = x - COORD_BITS'(1);
            closed[n].color   = open_color;
            closed[n].last    = 1'b0;
            n++;
            open_run = 1'b0;
        end
        if (in_arc && !open_run)
        begin
            open_run   = 1'b1;
            open_color = idx;
            open_x     = x;
        end
        // end of span closes the run at this pixel
        if (span_end && open_run)
        begin
            closed[n].row     = row;
            closed[n].first_x = open_x;
            closed[n].end_x   = x;
            closed[n].color   = open_color;
            closed[n].last    = 1'b0;
            n++;
            open_run = 1'b0;
        end
        if (n > 0)
            closed[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            runs_due.push_back(closed[k]);
    endfunction

    function automatic void compare_run(input run_t want, input run_t got);
        if (got.row !== want.row)
            note($sformatf("run_row expected %0d got %0d",
                           $signed(want.row), $signed(got.row)));
        if (got.first_x !== want.first_x)
            note($sformatf("run_start_x expected %0d got %0d",
                           $signed(want.first_x), $signed(got.first_x)));
        if (got.end_x !== want.end_x)
            note($sformatf("run_end_x expected %0d got %0d",
                           $signed(want.end_x), $signed(got.end_x)));
        if (got.color !== want.color)
            note($sformatf("color_index expected %0d got %0d", want.color, got.color));
        if (got.last !== want.last)
            note($sformatf("last expected %0d got %0d", want.last, got.last));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arc_origin = ARC_BASE_RST;
            arc_width  = ARC_WIDTH_RST;
            ramp_den   = RAMP_RANGE_RST;
            top_index  = CIDX_MAX_RST;
            open_run   = 1'b0;
            open_color = '0;
            open_x     = '0;
            runs_due.delete();
            errors     = 0;
            checked    = 0;
            fail_count   <= 0;
            runs_pending <= 0;
            runs_checked <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ARC_BASE:   arc_origin = cfg_wdata[ANGLE_BITS-1:0];
                    CFG_ARC_WIDTH:  arc_width  = cfg_wdata;
                    CFG_RAMP_RANGE: ramp_den   = cfg_wdata;
                    CFG_CIDX_MAX:   top_index  = cfg_wdata[CIDX_BITS-1:0];
                    default: ;
                endcase
            end

            // returned runs
            if (m_axis_tvalid && m_axis_tready)
            begin
                run_t got;
                got.row     = m_axis_tdata[COORD_BITS-1:0];
                got.first_x = m_axis_tdata[2*COORD_BITS-1:COORD_BITS];
                got.end_x   = m_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
                got.color   = m_axis_tdata[3*COORD_BITS+CIDX_BITS-1:3*COORD_BITS];
                got.last    = m_axis_tlast;
                if (runs_due.size() == 0)
                    note($sformatf("expected no run, got row %0d x %0d..%0d index %0d",
                                   $signed(got.row), $signed(got.first_x),
                                   $signed(got.end_x), got.color));
                else
                    compare_run(runs_due.pop_front(), got);
                checked++;
            end

            // accepted pixel requests
            if (s_axis_tvalid && s_axis_tready)
                merge_pixel(s_axis_tdata[COORD_BITS-1:0],
                            s_axis_tdata[2*COORD_BITS-1:COORD_BITS],
                            s_axis_tdata[2*COORD_BITS+ANGLE_BITS-1:2*COORD_BITS],
                            s_axis_tlast);

            fail_count   <= errors;
            runs_pending <= runs_due.size();
            runs_checked <= checked;
        end
    end

endmodule

// ===== tb/conic_gradient_run_merger_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conic_gradient_run_merger_test: regression for the conic gradient run merger
// Drives scanline spans of pixel requests under a series of register
// settings, with random gaps on the input and random stalls on the output,
// one long output hold and one stretch at full rate. The checker beside the
// block predicts and compares every run.
// ----------------------------------------------------------------------------
module conic_gradient_run_merger_test;
    import cgrm_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 8;
    localparam int PHASE_PIXELS  = 88;
    localparam int STEADY_PHASE  = 2;
    localparam int HOLD_PHASE    = 5;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    cfg_idx_t                  cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
    logic                      s_axis_tlast;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      m_axis_tlast;

    int fail_count;
    int runs_pending;
    int runs_checked;

    // traffic shaping
    bit src_steady;
    bit sink_steady;
    bit hold_req;

    int                    pixels_sent;
    int                    spans_sent;
    int                    settings;
    logic [ANGLE_BITS-1:0] cur_origin;

    conic_gradient_run_merger u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    conic_gradient_run_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .runs_pending  (runs_pending),
        .runs_checked  (runs_checked)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("watchdog: no completion after %0d cycles, %0d runs outstanding",
                 CYCLE_LIMIT, runs_pending);
        $display("conic_gradient_run_merger regression: fail");
        $finish;
    end

    // output side: random stalls, one long hold
    initial
    begin : run_sink
        int hold_left;
        bit hold_used;
        hold_left     = 0;
        hold_used     = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_steady)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 27);
        end
    end

    // one pixel request, with an optional random gap ahead of it
    task automatic send_pixel(input logic [COORD_BITS-1:0] row,
                              input logic [COORD_BITS-1:0] x,
                              input logic [ANGLE_BITS-1:0] ang,
                              input logic                  span_end);
        if (!src_steady)
            while ($urandom_range(99) < 27)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ang, x, row};
        s_axis_tlast  <= span_end;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pixels_sent++;
        if (span_end)
            spans_sent++;
    endtask

    // wait until every predicted run is back and the block has gone quiet
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (runs_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [ANGLE_BITS-1:0] origin,
                               input logic [RANGE_BITS-1:0] width,
                               input logic [RANGE_BITS-1:0] den,
                               input logic [CIDX_BITS-1:0]  top);
        put_reg(CFG_ARC_BASE, CFG_DATA_BITS'(origin));
        put_reg(CFG_ARC_WIDTH, width);
        put_reg(CFG_RAMP_RANGE, den);
        put_reg(CFG_CIDX_MAX, CFG_DATA_BITS'(top));
        cfg_we <= 1'b0;
        cur_origin = origin;
        settings++;
    endtask

    task automatic random_config;
        logic [ANGLE_BITS-1:0] origin;
        logic [RANGE_BITS-1:0] width;
        logic [RANGE_BITS-1:0] den;
        logic [CIDX_BITS-1:0]  top;
        origin = ANGLE_BITS'($urandom);
        case ($urandom_range(3))
            0:       width = 17'h10000;
            1:       width = 17'h1FFFF;
            2:       width = RANGE_BITS'($urandom_range(0, 65536));
            default: width = RANGE_BITS'($urandom_range(0, 4096));
        endcase
        case ($urandom_range(3))
            0:       den = 17'd1;
            1:       den = 17'h10000;
            2:       den = RANGE_BITS'($urandom);
            default: den = RANGE_BITS'($urandom_range(1, 4096));
        endcase
        case ($urandom_range(3))
            0:       top = 10'd1023;
            1:       top = 10'd1;
            2:       top = CIDX_BITS'($urandom);
            default: top = CIDX_BITS'($urandom_range(2, 64));
        endcase
        load_config(origin, width, den, top);
    endtask

    // one scanline span: a smooth angle sweep, or noise with jumps in
    // row, x and angle and sometimes no span end at all
    task automatic send_span(input int len, input bit noisy, input bit must_close);
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] x;
        logic [ANGLE_BITS-1:0] ang;
        int                    step;
        bit                    close;
        row   = COORD_BITS'($urandom);
        x     = COORD_BITS'($urandom);
        ang   = $urandom_range(1) ? cur_origin - ANGLE_BITS'($urandom_range(0, 300))
                                  : ANGLE_BITS'($urandom);
        step  = ($urandom_range(2) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 200);
        close = must_close || !noisy || $urandom_range(1);
        for (int i = 0; i < len; i++)
        begin
            send_pixel(row, x, ang, close && (i == len - 1));
            x = x + COORD_BITS'(1);
            if (noisy)
            begin
                ang = ANGLE_BITS'($urandom);
                if ($urandom_range(3) == 0)
                    x = COORD_BITS'($urandom);
                if ($urandom_range(3) == 0)
                    row = COORD_BITS'($urandom);
            end
            else
                ang = ang + ANGLE_BITS'(step + $urandom_range(0, 16));
        end
    endtask

    initial
    begin : stimulus
        int len;
        int sent;
        bit noisy;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_ARC_BASE;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        src_steady    = 1'b0;
        sink_steady   = 1'b0;
        hold_req      = 1'b0;
        pixels_sent   = 0;
        spans_sent    = 0;
        settings      = 1;
        cur_origin    = ARC_BASE_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: lowest row and x, angle extremes
        send_pixel(12'h800, 12'h800, 16'h0000, 1'b0);
        send_pixel(12'h800, 12'h801, 16'h0000, 1'b0);
        send_pixel(12'h800, 12'h802, 16'hFFFF, 1'b1);
        // x wraps from the top back to the bottom inside a span
        send_pixel(12'h7FF, 12'h7FE, 16'h4000, 1'b0);
        send_pixel(12'h7FF, 12'h7FF, 16'h4000, 1'b0);
        send_pixel(12'h7FF, 12'h800, 16'hC000, 1'b0);
        send_pixel(12'h7FF, 12'h801, 16'hC000, 1'b1);
        // closing pixel's row is carried by the run
        send_pixel(12'h001, 12'h000, 16'h0100, 1'b0);
        send_pixel(12'h002, 12'h001, 16'h9000, 1'b1);
        drain();

        // single-angle arc, zero ramp range, zero index maximum
        load_config(16'hFFFF, 17'd0, 17'd0, 10'd0);
        send_pixel(12'h000, 12'h010, 16'hFFFF, 1'b0);
        send_pixel(12'h000, 12'h011, 16'hFFFF, 1'b0);
        send_pixel(12'h000, 12'h012, 16'h0000, 1'b0);
        send_pixel(12'h000, 12'h013, 16'hFFFF, 1'b0);
        // span end outside the arc with a run open, then with none
        send_pixel(12'h000, 12'h014, 16'h1234, 1'b1);
        send_pixel(12'h000, 12'h015, 16'h0005, 1'b1);
        drain();

        // unit ramp, largest index: step from 0 to the cap, then a two-run end
        load_config(16'h8000, 17'h1FFFF, 17'd1, 10'd1023);
        send_pixel(12'h3C5, 12'h100, 16'h8000, 1'b0);
        send_pixel(12'h3C5, 12'h101, 16'h8001, 1'b0);
        send_pixel(12'h3C5, 12'h102, 16'h7FFF, 1'b0);
        send_pixel(12'h3C5, 12'h103, 16'h8000, 1'b1);
        drain();

        // arc boundary, widest ramp range
        load_config(16'h0100, 17'h000FF, 17'h1FFFF, 10'd1);
        send_pixel(12'h555, 12'h0AA, 16'h0100, 1'b0);
        send_pixel(12'h555, 12'h0AB, 16'h01FF, 1'b0);
        send_pixel(12'h555, 12'h0AC, 16'h0200, 1'b0);
        send_pixel(12'h555, 12'h0AD, 16'h00FF, 1'b1);
        drain();

        // random spans under a sequence of settings
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                load_config(16'h0000, 17'h10000, 17'h10000, 10'd1023);
            else if (p == 1)
                load_config(16'hFFFF, 17'd2000, 17'd1, 10'd1);
            else
                random_config();
            src_steady = (p == STEADY_PHASE) || (p == HOLD_PHASE);
            sink_steady <= (p == STEADY_PHASE);
            if (p == HOLD_PHASE)
                hold_req <= 1'b1;
            sent = 0;
            while (sent < PHASE_PIXELS)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
                if (len > PHASE_PIXELS - sent)
                    len = PHASE_PIXELS - sent;
                noisy = ($urandom_range(99) < 20);
                send_span(len, noisy, sent + len == PHASE_PIXELS);
                sent += len;
            end
            drain();
        end

        $display("summary: %0d pixels in %0d closed spans over %0d register settings, %0d runs compared",
                 pixels_sent, spans_sent, settings, runs_checked);
        $display("summary: zero ramp and zero index cases, x wrap, a %0d-cycle output hold, full-rate stretch",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("conic_gradient_run_merger regression: pass");
        else
            $display("conic_gradient_run_merger regression: fail");
        $finish;
    end

endmodule
